// File: hdl/cca_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package cca_pkg;

  localparam int RowW = 64;
  localparam int IdxW = 7;
  localparam int OutIdxW = 6;
  localparam int CfgIdxW = 3;
  localparam int CfgDataW = 7;

  localparam logic [CfgIdxW-1:0] CfgGridSize  = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgBirthLim  = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgDeathLim  = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgStepCount = 3'd3;

  localparam logic [6:0] GridSizeRst  = 7'd50;
  localparam logic [4:0] BirthLimRst  = 5'd4;
  localparam logic [4:0] DeathLimRst  = 5'd4;
  localparam logic [3:0] StepCountRst = 4'd8;

  typedef struct packed {
    logic [RowW-1:0] row_bits;
    logic            last_row;
  } in_t;

  typedef struct packed {
    logic [RowW-1:0]    out_row_bits;
    logic [OutIdxW-1:0] out_row_index;
    logic               out_last;
  } out_t;

  typedef enum logic [3:0] {
    ST_LOAD = 4'b0001,
    ST_GEN  = 4'b0010,
    ST_ERD  = 4'b0100,
    ST_ECAP = 4'b1000
  } state_t;

endpackage

`default_nettype wire

// File: hdl/cca_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module cca_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// File: hdl/cave_cellular_automaton_core.sv
`timescale 1ns / 1ps
`default_nettype none

// channel   direction  handshake             payload
// in_       input      in_valid/in_ready     cca_pkg::in_t (row_bits, last_row)
// out_      output     out_valid/out_ready   cca_pkg::out_t (row, index, last)
// cfg_      input      cfg_valid/cfg_ready   cfg_index, cfg_data
//
// a row request that is not the last one is stored
// the last row starts step_count generations, each reading one grid row
// from a ping-pong pair of row memories per cycle, then n result rows
// through a read state and a capture state; results stall while out_ready is low
// rst_n is synchronous; no clearing pass, a fill count masks rows not loaded
// in_ready is low from the last row until the final result row is registered

module cave_cellular_automaton_core #(
  parameter int MAX_GRID   = 64,
  parameter int CLEAR_HALF = 5
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire cca_pkg::in_t                in_data,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output cca_pkg::out_t                    out_data,
  input  wire logic                        cfg_valid,
  output logic                             cfg_ready,
  input  wire logic [cca_pkg::CfgIdxW-1:0] cfg_index,
  input  wire logic [cca_pkg::CfgDataW-1:0] cfg_data
);

  localparam int AW = $clog2(MAX_GRID);
  localparam int NW = $clog2(MAX_GRID + 1);
  localparam int KW = $clog2(MAX_GRID + 2);
  localparam int RW = cca_pkg::RowW;
  localparam int IW = cca_pkg::IdxW;

  cca_pkg::state_t state_r;

  logic [6:0]    grid_size_r;
  logic [4:0]    birth_lim_r;
  logic [4:0]    death_lim_r;
  logic [3:0]    step_count_r;

  logic [NW-1:0] ld_r;
  logic [NW-1:0] n_r;
  logic [IW-1:0] lo_r;
  logic [IW-1:0] hi_r;
  logic          raw_r;
  logic          src_r;
  logic [KW-1:0] k_r;
  logic [3:0]    gen_r;
  logic [AW-1:0] ey_r;
  logic [RW-1:0] up_r;
  logic [RW-1:0] mid_r;
  logic          up_out_r;
  logic          out_valid_r;
  cca_pkg::out_t out_r;

  logic          in_acc;
  logic          ld_room;
  logic [NW-1:0] ld_nxt;
  logic [6:0]    n_clamp;
  logic [7:0]    c8;
  logic [7:0]    lo8;
  logic [7:0]    hi8;

  logic [RW-1:0] gmask;
  logic [RW-1:0] cmask;
  logic [RW-1:0] rd0;
  logic [RW-1:0] rd1;
  logic [RW-1:0] rd_sel;
  logic [RW-1:0] gen_below;
  logic          gen_below_valid;
  logic          dn_out;
  logic [RW-1:0] new_row;
  logic [RW-1:0] emit_row;
  logic          emit_valid;
  logic          emit_clr;
  logic          emit_last;

  logic          gen_wr;
  logic          we0;
  logic          we1;
  logic [AW-1:0] waddr0;
  logic [RW-1:0] wdata0;
  logic [AW-1:0] gen_waddr;
  logic [AW-1:0] raddr;

  logic [RW-1:0] rows [3];
  logic          outs [3];
  logic [4:0]    cnt;
  int            col;

  assign in_ready  = (state_r == cca_pkg::ST_LOAD);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign in_acc    = in_valid && in_ready;
  assign ld_room   = (ld_r < NW'(MAX_GRID));
  assign ld_nxt    = ld_room ? ld_r + NW'(1) : ld_r;

  always_comb begin
    n_clamp = grid_size_r;
    if (n_clamp == 7'd0) begin
      n_clamp = 7'd1;
    end else if (8'(n_clamp) > 8'(MAX_GRID)) begin
      n_clamp = 7'(MAX_GRID);
    end
    c8  = 8'(n_clamp >> 1);
    lo8 = (c8 >= 8'(CLEAR_HALF)) ? c8 - 8'(CLEAR_HALF) : 8'd0;
    hi8 = c8 + 8'(CLEAR_HALF);
    if (hi8 > 8'(n_clamp)) begin
      hi8 = 8'(n_clamp);
    end
  end

  always_comb begin
    for (int x = 0; x < RW; x++) begin
      gmask[x] = (IW'(x) < IW'(n_r));
      cmask[x] = (IW'(x) >= lo_r) && (IW'(x) < hi_r);
    end
  end

  // row memories, bank 0 also takes the loaded rows
  assign gen_wr    = (state_r == cca_pkg::ST_GEN) && (k_r >= KW'(2));
  assign gen_waddr = AW'(k_r - KW'(2));
  assign we0       = (in_acc && ld_room) || (gen_wr && src_r);
  assign we1       = gen_wr && !src_r;
  assign waddr0    = in_acc ? AW'(ld_r) : gen_waddr;
  assign wdata0    = in_acc ? in_data.row_bits : new_row;
  assign raddr     = (state_r == cca_pkg::ST_GEN) ? AW'(k_r) : ey_r;
  assign rd_sel    = src_r ? rd1 : rd0;

  cca_ram #(.WIDTH(RW), .DEPTH(MAX_GRID)) u_bank0 (
    .clk   (clk),
    .we    (we0),
    .waddr (waddr0),
    .wdata (wdata0),
    .raddr (raddr),
    .rdata (rd0)
  );

  cca_ram #(.WIDTH(RW), .DEPTH(MAX_GRID)) u_bank1 (
    .clk   (clk),
    .we    (we1),
    .waddr (gen_waddr),
    .wdata (new_row),
    .raddr (raddr),
    .rdata (rd1)
  );

  // incoming row k_r-1 during a generation
  assign gen_below_valid = !raw_r || (8'(k_r) <= 8'(ld_r));
  assign gen_below       = gen_below_valid ? (rd_sel & gmask) : '0;
  assign dn_out          = (8'(k_r) == 8'(n_r) + 8'd1);

  always_comb begin
    rows[0] = up_r;
    rows[1] = mid_r;
    rows[2] = gen_below;
    outs[0] = up_out_r;
    outs[1] = 1'b0;
    outs[2] = dn_out;
    new_row = '0;
    for (int x = 0; x < RW; x++) begin
      cnt = 5'd0;
      for (int r = 0; r < 3; r++) begin
        for (int dx = -1; dx <= 1; dx++) begin
          col = x + dx;
          if (r != 1 || dx != 0) begin
            if (outs[r] || col < 0 || col >= int'(n_r)) begin
              cnt = cnt + 5'd2;
            end else begin
              cnt = cnt + 5'(rows[r][6'(col)]);
            end
          end
        end
      end
      new_row[x] = mid_r[x] ? (cnt >= death_lim_r) : (cnt > birth_lim_r);
    end
    new_row = new_row & gmask;
  end

  // result row with raw-row fill mask and centre clearing
  assign emit_valid = !raw_r || (IW'(ey_r) < IW'(ld_r));
  assign emit_clr   = (IW'(ey_r) >= lo_r) && (IW'(ey_r) < hi_r);
  assign emit_last  = (IW'(ey_r) == IW'(n_r) - IW'(1));
  always_comb begin
    emit_row = emit_valid ? (rd_sel & gmask) : '0;
    if (emit_clr) begin
      emit_row = emit_row & ~cmask;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_size_r  <= cca_pkg::GridSizeRst;
      birth_lim_r  <= cca_pkg::BirthLimRst;
      death_lim_r  <= cca_pkg::DeathLimRst;
      step_count_r <= cca_pkg::StepCountRst;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        cca_pkg::CfgGridSize:  grid_size_r  <= cfg_data;
        cca_pkg::CfgBirthLim:  birth_lim_r  <= cfg_data[4:0];
        cca_pkg::CfgDeathLim:  death_lim_r  <= cfg_data[4:0];
        cca_pkg::CfgStepCount: step_count_r <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= cca_pkg::ST_LOAD;
      ld_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        cca_pkg::ST_LOAD: begin
          if (in_acc) begin
            ld_r <= ld_nxt;
            if (in_data.last_row) begin
              n_r   <= NW'(n_clamp);
              lo_r  <= IW'(lo8);
              hi_r  <= IW'(hi8);
              raw_r <= 1'b1;
              src_r <= 1'b0;
              k_r   <= '0;
              gen_r <= '0;
              ey_r  <= '0;
              state_r <= (step_count_r == 4'd0) ? cca_pkg::ST_ERD : cca_pkg::ST_GEN;
            end
          end
        end
        cca_pkg::ST_GEN: begin
          if (k_r == KW'(1)) begin
            up_out_r <= 1'b1;
            mid_r    <= gen_below;
          end else if (k_r >= KW'(2)) begin
            up_out_r <= 1'b0;
            up_r     <= mid_r;
            mid_r    <= gen_below;
          end
          if (dn_out) begin
            k_r   <= '0;
            src_r <= !src_r;
            raw_r <= 1'b0;
            gen_r <= gen_r + 4'd1;
            if (gen_r + 4'd1 == step_count_r) begin
              state_r <= cca_pkg::ST_ERD;
            end
          end else begin
            k_r <= k_r + KW'(1);
          end
        end
        cca_pkg::ST_ERD: begin
          if (!out_valid_r || out_ready) begin
            state_r <= cca_pkg::ST_ECAP;
          end
        end
        cca_pkg::ST_ECAP: begin
          out_valid_r <= 1'b1;
          out_r.out_row_bits  <= emit_row;
          out_r.out_row_index <= cca_pkg::OutIdxW'(ey_r);
          out_r.out_last      <= emit_last;
          ey_r <= ey_r + AW'(1);
          if (emit_last) begin
            ld_r    <= '0;
            state_r <= cca_pkg::ST_LOAD;
          end else begin
            state_r <= cca_pkg::ST_ERD;
          end
        end
        default: state_r <= cca_pkg::ST_LOAD;
      endcase
    end
  end

endmodule

`default_nettype wire
